FILE: hdl/mcd_pkg.sv
package mcd_pkg;

   // Field and storage sizes of the contour detector.
   localparam int PixelBits  = 8;
   localparam int ColBits    = 10;
   localparam int RowBits    = 12;
   localparam int WidthBits  = 11;
   localparam int HeightBits = 13;
   localparam int CsrBits    = 13;
   localparam int LineDepth  = 1024;
   localparam int LineWord   = 2 * PixelBits;

   // Frame geometry limits.
   localparam logic [WidthBits-1:0]  MinWidth  = 11'd3;
   localparam logic [WidthBits-1:0]  MaxWidth  = 11'd1024;
   localparam logic [HeightBits-1:0] MinHeight = 13'd3;
   localparam logic [HeightBits-1:0] MaxHeight = 13'd4096;

   // Register values after reset.
   localparam logic [WidthBits-1:0]  ResetWidth     = 11'd1024;
   localparam logic [HeightBits-1:0] ResetHeight    = 13'd768;
   localparam logic [PixelBits-1:0]  ResetThreshold = 8'd60;

   // Register indexes of the write port.
   localparam logic [1:0] CsrImageWidth     = 2'd0;
   localparam logic [1:0] CsrImageHeight    = 2'd1;
   localparam logic [1:0] CsrAlphaThreshold = 2'd2;

   // Line buffer read request.
   typedef struct packed {
      logic               en;
      logic [ColBits-1:0] addr;
   } mcd_rd_type;

   // Line buffer write request.
   typedef struct packed {
      logic                en;
      logic [ColBits-1:0]  addr;
      logic [LineWord-1:0] data;
   } mcd_wr_type;

endpackage

FILE: hdl/mcd_line_ram.sv
// Both line buffers share one word: the upper byte holds the row two above the
// incoming pixel and the lower byte the row just above it. A read that hits the
// address written at the same edge returns the new word.
module mcd_line_ram import mcd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  mcd_rd_type          rd,
   input  mcd_wr_type          wr,
   output logic [LineWord-1:0] rd_data
);

   logic [LineWord-1:0] line_mem [LineDepth];
   logic [LineWord-1:0] rd_data_ff;
   logic [LineWord-1:0] fwd_data_ff;
   logic                fwd_sel_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff  <= line_mem[rd.addr];
         fwd_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_sel_ff <= 1'b0;
      end else if (rd.en) begin
         fwd_sel_ff <= wr.en && (wr.addr == rd.addr);
      end
   end

   assign rd_data = fwd_sel_ff ? fwd_data_ff : rd_data_ff;

endmodule

FILE: hdl/mask_contour_detect_top.sv
// Contour detector for an 8-bit alpha mask streamed in raster order, one pixel
// per transaction. It takes a pixel in every clock cycle unless the result
// side stalls it. An accepted pixel waits in the input stage while its line
// buffer read completes, and any result it causes is registered in the output
// register when the pixel leaves that stage. The single shared line buffer
// memory is read when a pixel is accepted and written when that pixel leaves
// the input stage. A pixel not on the image border is reported as a contour
// pixel when it is strictly above the threshold and at least one of its four
// diagonal neighbors is strictly below the threshold. Its row and column come
// out as one transaction when the pixel one row below and one column to the
// right of it arrives, so the last row and column of a frame are never
// reported. The tuser bit marks the first pixel of a frame and restarts the
// position counters; without it, counting wraps to a new frame after the last
// row by itself. Width and height below 3 act as 3, and above 1024 and 4096
// respectively act as those limits. Line buffer contents are undefined after
// reset; the user must see that they are only read for a result after they have
// been written within a frame of the current width, and must write configuration
// only while no transaction is in flight. The block itself enforces neither rule.
module mask_contour_detect_top import mcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [7:0] pixel_alpha
   input  logic [0:0]            req_tuser,  // [0] frame_start

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,  // [11:0] contour_row, [21:12] contour_col, zero pad

   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CsrBits-1:0]    csr_wdata
);

   // Configuration registers.
   logic [WidthBits-1:0]  width_ff;
   logic [HeightBits-1:0] height_ff;
   logic [PixelBits-1:0]  thresh_ff;
   logic [WidthBits-1:0]  width_eff;
   logic [HeightBits-1:0] height_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ResetWidth;
         height_ff <= ResetHeight;
         thresh_ff <= ResetThreshold;
      end else if (csr_we) begin
         case (csr_index)
            CsrImageWidth:     width_ff  <= csr_wdata[WidthBits-1:0];
            CsrImageHeight:    height_ff <= csr_wdata[HeightBits-1:0];
            CsrAlphaThreshold: thresh_ff <= csr_wdata[PixelBits-1:0];
            default: ;
         endcase
      end
   end

   // Out-of-range sizes are clamped to the supported frame geometry.
   always_comb begin
      if (width_ff < MinWidth) begin
         width_eff = MinWidth;
      end else if (width_ff > MaxWidth) begin
         width_eff = MaxWidth;
      end else begin
         width_eff = width_ff;
      end
      if (height_ff < MinHeight) begin
         height_eff = MinHeight;
      end else if (height_ff > MaxHeight) begin
         height_eff = MaxHeight;
      end else begin
         height_eff = height_ff;
      end
   end

   // Handshake between the input stage and the output register.
   logic req_fire;
   logic advance;
   logic s1_valid_ff;
   logic rsp_valid_ff;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // Position of the incoming pixel. A frame start forces it to the origin.
   logic [ColBits-1:0] col_ff, col_in, cur_col;
   logic [RowBits-1:0] row_ff, row_in, cur_row;
   logic               col_wrap, row_wrap;

   always_comb begin
      cur_col  = req_tuser[0] ? '0 : col_ff;
      cur_row  = req_tuser[0] ? '0 : row_ff;
      col_wrap = ({1'b0, cur_col} + 11'd1) >= width_eff;
      row_wrap = ({1'b0, cur_row} + 13'd1) >= height_eff;
      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : cur_row + 12'd1;
      end else begin
         col_in = cur_col + 10'd1;
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Input stage: the pixel and its position wait here while the line buffer
   // read completes.
   logic [PixelBits-1:0] s1_pix_ff;
   logic [ColBits-1:0]   s1_col_ff;
   logic [RowBits-1:0]   s1_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff <= req_tdata[PixelBits-1:0];
         s1_col_ff <= cur_col;
         s1_row_ff <= cur_row;
      end
   end

   // Line buffers. When the pixel leaves the input stage, the row above moves
   // up one buffer and the pixel itself enters the lower buffer.
   mcd_rd_type          lb_rd;
   mcd_wr_type          lb_wr;
   logic [LineWord-1:0] lb_data;
   logic [PixelBits-1:0] up_pix;
   logic [PixelBits-1:0] low_pix;

   assign up_pix  = lb_data[LineWord-1:PixelBits];
   assign low_pix = lb_data[PixelBits-1:0];

   always_comb begin
      lb_rd.en   = req_fire;
      lb_rd.addr = cur_col;
      lb_wr.en   = advance;
      lb_wr.addr = s1_col_ff;
      lb_wr.data = {low_pix, s1_pix_ff};
   end

   mcd_line_ram u_line_ram (
      .clock   (clock),
      .reset   (reset),
      .rd      (lb_rd),
      .wr      (lb_wr),
      .rd_data (lb_data)
   );

   // Window columns one and two behind the incoming pixel. The centre is the
   // row above, one column back; the diagonals are the far corners of the 3x3.
   logic [PixelBits-1:0] win_up1_ff, win_up2_ff;
   logic [PixelBits-1:0] win_mid1_ff;
   logic [PixelBits-1:0] win_cur1_ff, win_cur2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_up1_ff  <= '0;
         win_up2_ff  <= '0;
         win_mid1_ff <= '0;
         win_cur1_ff <= '0;
         win_cur2_ff <= '0;
      end else if (advance) begin
         win_up2_ff  <= win_up1_ff;
         win_cur2_ff <= win_cur1_ff;
         win_up1_ff  <= up_pix;
         win_mid1_ff <= low_pix;
         win_cur1_ff <= s1_pix_ff;
      end
   end

   logic interior;
   logic below;
   logic hit;

   assign interior = (s1_row_ff >= 12'd2) && (s1_col_ff >= 10'd2);
   assign below    = (win_up2_ff < thresh_ff) || (up_pix < thresh_ff) ||
                     (win_cur2_ff < thresh_ff) || (s1_pix_ff < thresh_ff);
   assign hit      = interior && (win_mid1_ff > thresh_ff) && below;

   // Output register.
   logic [RowBits-1:0] rsp_row_ff;
   logic [ColBits-1:0] rsp_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= hit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_row_ff <= s1_row_ff - 12'd1;
         rsp_col_ff <= s1_col_ff - 10'd1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_col_ff, rsp_row_ff};

   // A pixel held in the input stage keeps its position while it waits.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_col_ff) && $stable(s1_row_ff))
      else $error("input stage lost or changed a waiting pixel");

   // A new result only appears when a pixel has left the input stage.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result raised without a pixel leaving the input stage");

   // A frame start always places the following pixel at column one.
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser[0] |=> col_ff == 10'd1)
      else $error("column counter wrong after frame start");

   // Reported positions are never on the top or left border.
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff != '0) && (rsp_col_ff != '0))
      else $error("contour reported on the image border");

endmodule

FILE: tb/contour_check_pkg.sv
package contour_check_pkg;
   import mcd_pkg::*;

   // Position of one contour pixel as the block reports it.
   typedef struct packed {
      bit [RowBits-1:0] row;
      bit [ColBits-1:0] col;
   } contour_pos_type;

   class contour_tracker;
      bit [WidthBits-1:0]  width_reg;
      bit [HeightBits-1:0] height_reg;
      bit [PixelBits-1:0]  threshold_reg;

      bit [PixelBits-1:0]  upper_line [LineDepth];
      bit [PixelBits-1:0]  lower_line [LineDepth];
      // Window taps one and two columns left of the incoming pixel.
      bit [PixelBits-1:0]  top_c1, top_c2, mid_c1, bot_c1, bot_c2;
      bit [ColBits-1:0]    col_pos;
      bit [RowBits-1:0]    row_pos;

      contour_pos_type     due_contours [$];
      int                  errors;
      int                  pixels_seen;
      int                  contours_seen;

      function new();
         width_reg     = ResetWidth;
         height_reg    = ResetHeight;
         threshold_reg = ResetThreshold;
      endfunction

      function int span(int value, int lo, int hi);
         return (value < lo) ? lo : ((value > hi) ? hi : value);
      endfunction

      function int pending();
         return due_contours.size();
      endfunction

      function void set_reg(logic [1:0] index, logic [CsrBits-1:0] value);
         case (index)
            CsrImageWidth:     width_reg     = value[WidthBits-1:0];
            CsrImageHeight:    height_reg    = value[HeightBits-1:0];
            CsrAlphaThreshold: threshold_reg = value[PixelBits-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(bit [PixelBits-1:0] alpha, bit frame_start);
         int                 w;
         int                 h;
         bit [PixelBits-1:0] up;
         bit [PixelBits-1:0] low;
         bit                 diag_below;
         contour_pos_type    pos;
         w = span(width_reg, MinWidth, MaxWidth);
         h = span(height_reg, MinHeight, MaxHeight);
         pixels_seen++;
         if (frame_start) begin
            col_pos = '0;
            row_pos = '0;
         end
         up  = upper_line[col_pos];
         low = lower_line[col_pos];
         // The centre is one row up and one column left of the incoming pixel.
         if (row_pos >= 2 && col_pos >= 2) begin
            diag_below = top_c2 < threshold_reg || up < threshold_reg ||
                         bot_c2 < threshold_reg || alpha < threshold_reg;
            if (mid_c1 > threshold_reg && diag_below) begin
               pos.row = row_pos - 1'b1;
               pos.col = col_pos - 1'b1;
               due_contours = {due_contours, pos};
            end
         end
         top_c2 = top_c1;
         bot_c2 = bot_c1;
         top_c1 = up;
         mid_c1 = low;
         bot_c1 = alpha;
         upper_line[col_pos] = low;
         lower_line[col_pos] = alpha;
         if (int'(col_pos) + 1 >= w) begin
            col_pos = '0;
            row_pos = (int'(row_pos) + 1 >= h) ? '0 : row_pos + 1'b1;
         end else begin
            col_pos = col_pos + 1'b1;
         end
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) begin
            $display("%0t ns: mismatch: %s", $time, what);
         end
      endtask

      task check_contour(bit [RowBits-1:0] row, bit [ColBits-1:0] col);
         contour_pos_type due;
         contours_seen++;
         if (due_contours.size() == 0) begin
            report($sformatf("contour at row %0d col %0d was not predicted", row, col));
         end else begin
            due = due_contours.pop_front();
            if (row != due.row) begin
               report($sformatf("row %0d, predicted %0d", row, due.row));
            end
            if (col != due.col) begin
               report($sformatf("col %0d, predicted %0d", col, due.col));
            end
         end
      endtask
   endclass

endpackage

FILE: tb/tb_mask_contour_detect_top.sv
module tb_mask_contour_detect_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mcd_pkg::*;
   import contour_check_pkg::*;

   // A stretch this long without any accepted transaction means the block hung.
   localparam int QuietLimit  = 4000;
   // Cycles allowed after the last predicted contour for pixels still in flight.
   localparam int DrainCycles = 16;
   // Length of the one long hold-off on the result channel.
   localparam int LongHold    = 300;

   // Hand-built 3 x 6 frame followed by a restart in the middle of a row.
   // Centres (1,1), (2,1), (3,1) and (4,1) are each a contour through exactly one
   // diagonal: up-left, up-right, down-left and down-right in that order. The
   // other diagonals sit at or above the threshold of 100, so equality is seen
   // as not below. After the frame the counters wrap by themselves, and the
   // pixel at ProbeRestart carries a frame start in the middle of a row.
   localparam int ProbeCount   = 25;
   localparam int ProbeRestart = 22;
   localparam logic [PixelBits-1:0] ProbeAlpha [ProbeCount] = '{
      8'd99,  8'd0,   8'd100,
      8'd100, 8'd101, 8'd0,
      8'd255, 8'd255, 8'd100,
      8'd200, 8'd200, 8'd200,
      8'd50,  8'd150, 8'd255,
      8'd255, 8'd255, 8'd0,
      8'd100, 8'd100, 8'd100,
      8'd100, 8'd255, 8'd0, 8'd255
   };

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;   // [7:0] pixel_alpha
   logic [0:0]           req_tuser  = '0;   // [0] frame_start
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;         // [11:0] contour_row, [21:12] contour_col
   logic                 csr_we     = 1'b0;
   logic [1:0]           csr_index  = CsrImageWidth;
   logic [CsrBits-1:0]   csr_wdata  = '0;

   // Idling control: percent of cycles in which each side holds back.
   int                   send_idle_pct  = 0;
   int                   recv_stall_pct = 0;
   bit                   long_hold_req  = 1'b0;
   bit                   long_hold_done = 1'b0;
   int                   held_cycles    = 0;
   int                   quiet_cycles   = 0;
   int                   settings_run   = 0;
   logic [PixelBits-1:0] alpha_level    = ResetThreshold;

   contour_tracker       board = new();

   mask_contour_detect_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Both channels are sampled at the rising edge, where every input still
   // holds the value that the nonblocking drives set up before it. Each
   // accepted pixel feeds the predictor before any result of the same edge is
   // checked; a result can never belong to a pixel of its own edge anyway.
   // The same process keeps the watchdog, which counts edges with no
   // transaction on either channel.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         board.note_pixel(req_tdata, req_tuser[0]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_contour(rsp_tdata[RowBits-1:0], rsp_tdata[RowBits+ColBits-1:RowBits]);
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t ns: no transaction for %0d cycles", $time, QuietLimit);
         $display("** mask_contour_detect_top: FAILED **");
         $finish;
      end
   end

   // Result side. Once asked, it holds tready low for LongHold cycles, counted
   // here, so that the block's output fills and it must stall the pixel
   // stream. Otherwise it stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      if (long_hold_req && !long_hold_done) begin
         rsp_tready <= 1'b0;
         held_cycles++;
         if (held_cycles >= LongHold) begin
            long_hold_done = 1'b1;
         end
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one pixel, after a random number of idle cycles, and returns at the
   // edge where the transaction completes. Valid is only lowered when an idle
   // cycle actually follows, so a back-to-back pixel keeps it high.
   task automatic send_pixel(input logic [PixelBits-1:0] alpha, input logic frame_start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= alpha;
      req_tuser  <= frame_start;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // Waits until every predicted contour has come out, then lets pixels that
   // cause no result clear the pipeline before anything is reconfigured.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges with the enable held high.
   task automatic write_settings(input int width, input int height, input int threshold);
      csr_we    <= 1'b1;
      csr_index <= CsrImageWidth;
      csr_wdata <= CsrBits'(width);
      @(posedge clock);
      csr_index <= CsrImageHeight;
      csr_wdata <= CsrBits'(height);
      @(posedge clock);
      csr_index <= CsrAlphaThreshold;
      csr_wdata <= CsrBits'(threshold);
      @(posedge clock);
      csr_we    <= 1'b0;
      board.set_reg(CsrImageWidth, CsrBits'(width));
      board.set_reg(CsrImageHeight, CsrBits'(height));
      board.set_reg(CsrAlphaThreshold, CsrBits'(threshold));
      alpha_level = threshold[PixelBits-1:0];
      settings_run++;
   endtask

   // Mask-like pixels: often fully off or on, often right at the threshold
   // or one step either side of it, and the rest uniform.
   function automatic logic [PixelBits-1:0] pick_alpha();
      case ($urandom_range(7))
         0:       pick_alpha = 8'h00;
         1:       pick_alpha = 8'hFF;
         2:       pick_alpha = alpha_level;
         3:       pick_alpha = alpha_level + 8'd1;
         4:       pick_alpha = alpha_level - 8'd1;
         default: pick_alpha = 8'($urandom);
      endcase
   endfunction

   // One phase: new settings while idle, then a stream of pixels. A phase that
   // makes the image wider must open a new frame, since the columns beyond the
   // old width were not written in the current frame. Stray frame starts come
   // at the given rate per thousand pixels.
   task automatic run_phase(input int width, input int height, input int threshold,
                            input int count, input int send_pct, input int recv_pct,
                            input bit new_frame, input int restart_permille);
      logic frame_start;
      write_settings(width, height, threshold);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         frame_start = (n == 0) ? new_frame : ($urandom_range(999) < restart_permille);
         send_pixel(pick_alpha(), frame_start);
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frame: each diagonal on its own, pixel extremes, the
      // automatic wrap to a new frame and a restart in the middle of a row.
      write_settings(3, 6, 100);
      for (int i = 0; i < ProbeCount; i++) begin
         send_pixel(ProbeAlpha[i], i == 0 || i == ProbeRestart);
      end
      drain();

      // Random phases over sizes, thresholds and idling patterns.
      run_phase(5, 4, 128, 250, 0, 0, 1'b1, 0);
      // Width and height below the minimum act as 3; threshold 0 finds nothing.
      run_phase(0, 2, 0, 150, 76, 0, 1'b1, 10);
      // Height 1 acts as 3; threshold 255 finds nothing.
      run_phase(7, 1, 255, 150, 0, 76, 1'b1, 10);
      // Height register at its maximum acts as 4096, so rows keep counting.
      run_phase(16, 8191, 60, 300, 30, 30, 1'b1, 5);

      // The result side holds off for a long stretch while pixels keep coming.
      // No stray frame starts, so the phase ends at row 3, column 7.
      long_hold_req = 1'b1;
      run_phase(9, 6, 128, 250, 0, 0, 1'b1, 0);

      // Narrower and shorter without a new frame: the column counter is past
      // the new width and the row past the new height, so both wrap at once.
      run_phase(4, 3, 90, 150, 30, 30, 1'b0, 10);

      // Width register at its maximum acts as 1024; a short run that stays
      // within the first row of such a frame.
      run_phase(2047, 3, 128, 75, 0, 30, 1'b1, 0);

      run_phase(12, 5, 200, 250, 76, 0, 1'b1, 10);
      run_phase(3, 4096, 30, 150, 0, 76, 1'b1, 0);

      $display("Streamed %0d pixels and checked %0d contour transactions over %0d settings,",
               board.pixels_seen, board.contours_seen, settings_run);
      $display("with size clamps, counter wraps, frame restarts and a %0d-cycle output hold.",
               LongHold);
      if (board.errors == 0) begin
         $display("** mask_contour_detect_top: PASSED **");
      end else begin
         $display("** mask_contour_detect_top: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/mcd_pkg.sv
hdl/mcd_line_ram.sv
hdl/mask_contour_detect_top.sv
tb/contour_check_pkg.sv
tb/tb_mask_contour_detect_top.sv
